// ===== rtl/averaged_hysteresis_thermostat_core_defines.svh =====
// Assertion helpers used by the thermostat window stage.
// Each one is checked on the rising edge of clk and is off while rst is high.
`ifndef AVERAGED_HYSTERESIS_THERMOSTAT_CORE_DEFINES_SVH
`define AVERAGED_HYSTERESIS_THERMOSTAT_CORE_DEFINES_SVH

// The condition holds at every clock edge.
`define AHT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define AHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define AHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aht_pkg.sv =====
package aht_pkg;

  localparam int WINDOW_DEFAULT = 10;
  localparam int RAW_W          = 16;
  localparam int RAW_SHIFT      = 5;
  localparam int READ_W         = RAW_W - RAW_SHIFT;
  localparam int SUM_W          = 15;
  localparam int TEMP_W         = 8;
  localparam logic [TEMP_W-1:0] TARGET_RESET = 8'd175;

  // Item handed from the window stage to the regulation stage.
  typedef struct packed {
    logic [READ_W-1:0] reading;
    logic [SUM_W-1:0]  sum;
    logic              active;
  } win_item_t;

endpackage

// ===== rtl/aht_ram.sv =====
module aht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/aht_window.sv =====
`include "averaged_hysteresis_thermostat_core_defines.svh"

module aht_window #(
  parameter int WINDOW = aht_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aht_pkg::RAW_W-1:0]     raw_word,
  input  logic                          out_free,
  output logic                          s2_v,
  output aht_pkg::win_item_t            s2
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic                          accept;
  logic                          s1_v;
  logic                          s1_adv;
  logic                          s2_free;
  logic [PTR_W-1:0]              wr_pos;
  logic [PTR_W-1:0]              s1_pos;
  logic [CNT_W-1:0]              fill_count;
  logic                          fill_done;
  logic [aht_pkg::READ_W-1:0]    s1_reading;
  logic                          s1_active;
  logic                          s1_old_valid;
  logic [WINDOW-1:0]             ent_valid;
  logic [aht_pkg::READ_W-1:0]    ram_q;
  logic [aht_pkg::READ_W-1:0]    old_val;
  logic [aht_pkg::SUM_W-1:0]     window_sum;
  logic [aht_pkg::SUM_W-1:0]     sum_next;

  // stage handshake
  assign s2_free  = !s2_v || out_free;
  assign s1_adv   = s1_v && s2_free;
  assign in_stall = s1_v && !s2_free;
  assign accept   = in_valid && !in_stall;

  assign fill_done = (fill_count == CNT_W'(WINDOW));

  // never-written entries read as zero
  assign old_val  = s1_old_valid ? ram_q : '0;
  assign sum_next = window_sum - aht_pkg::SUM_W'(old_val)
                  + aht_pkg::SUM_W'(s1_reading);

  aht_ram #(
    .WIDTH (aht_pkg::READ_W),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos),
    .wdata (s1_reading),
    .re    (accept),
    .raddr (wr_pos),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos     <= '0;
      fill_count <= '0;
      ent_valid  <= '0;
      window_sum <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
    end else begin
      if (accept) begin
        wr_pos <= (wr_pos == PTR_W'(WINDOW - 1)) ? '0 : wr_pos + PTR_W'(1);
        if (!fill_done) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        window_sum        <= sum_next;
        ent_valid[s1_pos] <= 1'b1;
        s2_v              <= 1'b1;
      end else if (out_free) begin
        s2_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos       <= wr_pos;
      s1_reading   <= raw_word[aht_pkg::RAW_W-1:aht_pkg::RAW_SHIFT];
      s1_active    <= fill_done;
      s1_old_valid <= ent_valid[wr_pos];
    end
    if (s1_adv) begin
      s2.reading <= s1_reading;
      s2.sum     <= sum_next;
      s2.active  <= s1_active;
    end
  end

  `AHT_ASSERT_ALWAYS(a_pos_range, wr_pos <= PTR_W'(WINDOW - 1), "write position out of range")
  `AHT_ASSERT_ALWAYS(a_fill_range, fill_count <= CNT_W'(WINDOW), "fill count past window")
  `AHT_ASSERT_IMP(a_full_valid, fill_done && !s1_v, &ent_valid, "full window has unwritten entry")
  `AHT_ASSERT_NXT(a_s1_hold, s1_v && !s2_free, s1_v && $stable(s1_pos), "stalled item lost")

endmodule

// ===== rtl/aht_ctrl.sv =====
module aht_ctrl #(
  parameter int WINDOW = aht_pkg::WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aht_pkg::TEMP_W-1:0]   target_temp,
  input  logic                         s2_v,
  input  aht_pkg::win_item_t           s2,
  output logic                         out_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [aht_pkg::READ_W-1:0]   reading,
  output logic [aht_pkg::READ_W-1:0]   average,
  output logic                         heater_on,
  output logic                         sensor_fault,
  output logic                         window_full
);

  // divide by WINDOW as multiply by a rounded-up reciprocal; exact for any 15-bit sum
  localparam int SHIFT  = aht_pkg::SUM_W + $clog2(WINDOW);
  localparam int MULT_W = SHIFT + 1;
  localparam int PROD_W = aht_pkg::SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT = MULT_W'(((64'd1 << SHIFT) + WINDOW - 1) / WINDOW);

  logic                        s2_adv;
  logic [aht_pkg::TEMP_W-1:0]  setpoint;
  logic                        heater_state;
  logic                        heat_next;
  logic [PROD_W-1:0]           prod;
  logic [aht_pkg::READ_W-1:0]  avg;
  logic                        fault;
  logic                        too_hot;
  logic                        too_cold;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign s2_adv    = s2_v && out_free;

  assign prod  = PROD_W'(s2.sum) * PROD_W'(MULT);
  assign avg   = prod[SHIFT +: aht_pkg::READ_W];
  assign fault = (s2.reading == '0);

  // avg > target+1 and avg < target-1, target taken as unsigned
  assign too_hot  = 12'(avg) > 12'(setpoint) + 12'd1;
  assign too_cold = 12'(avg) + 12'd1 < 12'(setpoint);

  always_comb begin
    heat_next = heater_state;
    if (s2.active) begin
      if (too_hot && heat_next) begin
        heat_next = 1'b0;
      end
      if (too_cold && !heat_next) begin
        heat_next = 1'b1;
      end
    end
    if (fault) begin
      heat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= aht_pkg::TARGET_RESET;
      heater_state <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        setpoint <= target_temp;
      end
      if (s2_adv) begin
        heater_state <= heat_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      reading      <= s2.reading;
      average      <= avg;
      heater_on    <= heat_next;
      sensor_fault <= fault;
      window_full  <= s2.active;
    end
  end

endmodule

// ===== rtl/averaged_hysteresis_thermostat_core.sv =====
// Bang-bang thermostat on a moving average of converter samples. Each accepted
// raw_word is shifted right by five to whole degrees (reading); the last WINDOW
// readings live in a small history RAM (one read port, one write port, registered
// read) that starts out all zero, and a running sum of that RAM gives average =
// sum / WINDOW, truncated. Zeros from reset count in the average until the
// history has been refilled. After WINDOW earlier samples, the heater turns off
// when the average is above target+1 and on when it is below target-1, and holds
// in between. A zero reading flags sensor_fault and forces the heater off. Each
// input transfer yields exactly one output transfer, passing the s1 register, the
// s2 register and the output register; one item per cycle is taken unless a
// stalled output backs up into in_stall, with the history RAM and running sum
// read, updated and written back for each item. Reset needs no clearing pass:
// per-entry valid bits mark which history entries have been written. target_temp
// (reset 175) is written over the cfg channel, which is always ready; write it
// only while the block is idle.
module averaged_hysteresis_thermostat_core #(
  parameter int WINDOW = aht_pkg::WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // sample input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [aht_pkg::RAW_W-1:0]    raw_word,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aht_pkg::TEMP_W-1:0]   target_temp,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [aht_pkg::READ_W-1:0]   reading,
  output logic [aht_pkg::READ_W-1:0]   average,
  output logic                         heater_on,
  output logic                         sensor_fault,
  output logic                         window_full
);

  logic               s2_v;
  logic               out_free;
  aht_pkg::win_item_t s2;

  // History RAM, fill count and running sum.
  aht_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .raw_word (raw_word),
    .out_free (out_free),
    .s2_v     (s2_v),
    .s2       (s2)
  );

  // Averaging, hysteresis, fault override and the output register.
  aht_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .target_temp  (target_temp),
    .s2_v         (s2_v),
    .s2           (s2),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reading      (reading),
    .average      (average),
    .heater_on    (heater_on),
    .sensor_fault (sensor_fault),
    .window_full  (window_full)
  );

endmodule
